// ----- src/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and codes for the request match queue
// Entry layout, item modes, status codes and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int HandleWidth = 16;
   localparam int SourceWidth = 16;
   localparam int TagWidth    = 16;
   localparam int CommWidth   = 8;
   localparam int ModeWidth   = 2;
   localparam int StatusWidth = 2;
   localparam int OccWidth    = 5;

   // item modes
   localparam logic [ModeWidth-1:0] MODE_ENQ   = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_DEQ   = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_MATCH = 2'd2;

   // result status codes
   localparam logic [StatusWidth-1:0] ST_DONE = 2'd0;
   localparam logic [StatusWidth-1:0] ST_NONE = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [HandleWidth-1:0] handle;
      logic [SourceWidth-1:0] source;
      logic [TagWidth-1:0]    tag;
      logic [CommWidth-1:0]   comm;
   } rmq_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic                   start;      // latch request, clear scan state
      logic                   enq_write;  // store request entry at tail
      logic                   eval;       // evaluate read data of current slot
      logic                   inc_count;
      logic                   dec_count;
      logic                   set_status;
      logic [StatusWidth-1:0] status_code;
      logic                   load_out;   // move result into output register
   } rmq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic last;   // current slot is the tail
      logic hit;    // current slot matches the query, or any slot on dequeue
      logic found;  // a slot was removed earlier in this scan
   } rmq_stat_type;

endpackage

// ----- src/rmq_req_if.sv -----
// ----------------------------------------------------------------------------
// rmq_req_if: request channel
// Valid/ready channel carrying one queue operation.
// ----------------------------------------------------------------------------
interface rmq_req_if;
   logic                               valid;
   logic                               ready;
   logic [rmq_pkg::ModeWidth-1:0]      mode;
   logic [rmq_pkg::HandleWidth-1:0]    entry_handle;
   logic [rmq_pkg::SourceWidth-1:0]    entry_source;
   logic [rmq_pkg::TagWidth-1:0]       entry_tag;
   logic [rmq_pkg::CommWidth-1:0]      entry_comm;
   logic [rmq_pkg::SourceWidth-1:0]    query_source;
   logic [rmq_pkg::TagWidth-1:0]       query_tag;
   logic [rmq_pkg::CommWidth-1:0]      query_comm;
   logic                               any_source;
   logic                               any_tag;

   modport source (
      output valid, mode, entry_handle, entry_source, entry_tag, entry_comm,
             query_source, query_tag, query_comm, any_source, any_tag,
      input  ready
   );

   modport sink (
      input  valid, mode, entry_handle, entry_source, entry_tag, entry_comm,
             query_source, query_tag, query_comm, any_source, any_tag,
      output ready
   );
endinterface

// ----- src/rmq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rmq_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface rmq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rmq_pkg::StatusWidth-1:0]    status;
   logic [rmq_pkg::HandleWidth-1:0]    found_handle;
   logic [rmq_pkg::OccWidth-1:0]       occupancy;

   modport source (
      output valid, status, found_handle, occupancy,
      input  ready
   );

   modport sink (
      input  valid, status, found_handle, occupancy,
      output ready
   );
endinterface

// ----- src/request_match_queue_core.sv -----
// ----------------------------------------------------------------------------
// request_match_queue_core: ordered queue of pending message requests
// Enqueue at tail, dequeue head, or remove the oldest entry matching a
// communicator, source and tag (source and tag may be wildcards).
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+---------------------------------------
//   req_bus  | in  | valid/ready  | mode, entry_*, query_*, any_source/tag
//   rsp_bus  | out | valid/ready  | status, found_handle, occupancy
//
// One operation at a time. Enqueue runs S_ENQ then S_FINISH and the unused
// mode goes straight to S_FINISH; dequeue and match run S_READ and S_EVAL
// for each entry held, a read-then-evaluate walk over the one RAM read port.
// Synchronous reset empties the queue; slot contents are not cleared.
// A new request is taken while the previous result waits in the output
// register; the block stalls only to hand off its next result.
// ----------------------------------------------------------------------------
module request_match_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_bus,
   rmq_rsp_if.source rsp_bus
);

   rmq_pkg::rmq_cmd_type  cmd;
   rmq_pkg::rmq_stat_type stat;

   rmq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rmq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule

// ----- src/rmq_ram.sv -----
// ----------------------------------------------------------------------------
// rmq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rmq_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rmq_datapath.sv -----
// ----------------------------------------------------------------------------
// rmq_datapath: slot storage, scan index and result registers
// Entries sit in RAM in age order from address 0. A removal compacts the
// entries behind the removed one by rewriting each one slot lower.
// ----------------------------------------------------------------------------
module rmq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   rmq_req_if.sink               req_bus,
   rmq_rsp_if.source             rsp_bus,
   input  rmq_pkg::rmq_cmd_type  cmd,
   output rmq_pkg::rmq_stat_type stat
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   // latched request
   logic [rmq_pkg::ModeWidth-1:0]   mode_ff;
   rmq_pkg::rmq_entry_type          entry_ff;
   logic [rmq_pkg::SourceWidth-1:0] q_source_ff;
   logic [rmq_pkg::TagWidth-1:0]    q_tag_ff;
   logic [rmq_pkg::CommWidth-1:0]   q_comm_ff;
   logic                            any_source_ff;
   logic                            any_tag_ff;

   logic [CntW-1:0]                 count_ff;
   logic [IdxW-1:0]                 idx_ff;
   logic                            found_ff;
   logic [rmq_pkg::HandleWidth-1:0] handle_ff;
   logic [rmq_pkg::StatusWidth-1:0] status_ff;

   logic [rmq_pkg::StatusWidth-1:0] out_status_ff;
   logic [rmq_pkg::HandleWidth-1:0] out_handle_ff;
   logic [rmq_pkg::OccWidth-1:0]    out_occ_ff;

   rmq_pkg::rmq_entry_type          rd_entry;
   rmq_pkg::rmq_entry_type          wr_entry;
   logic [$bits(rmq_pkg::rmq_entry_type)-1:0] rd_bits;
   logic                            wr_en;
   logic                            shift_wr;
   logic [IdxW-1:0]                 wr_addr;
   logic                            query_hit;

   assign rd_entry = rmq_pkg::rmq_entry_type'(rd_bits);

   always_comb begin
      query_hit = (any_source_ff || (rd_entry.source == q_source_ff)) &&
                  (any_tag_ff || (rd_entry.tag == q_tag_ff)) &&
                  (rd_entry.comm == q_comm_ff);
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CntW'(DEPTH));
   assign stat.last  = (CntW'(idx_ff) == (count_ff - CntW'(1)));
   assign stat.hit   = (mode_ff == rmq_pkg::MODE_DEQ) || query_hit;
   assign stat.found = found_ff;

   // once the removed slot is behind the scan, each later entry moves down one
   assign shift_wr = cmd.eval && found_ff;
   assign wr_en    = cmd.enq_write || shift_wr;
   assign wr_addr  = cmd.enq_write ? count_ff[IdxW-1:0] : (idx_ff - IdxW'(1));
   assign wr_entry = cmd.enq_write ? entry_ff : rd_entry;

   rmq_ram #(
      .WIDTH ($bits(rmq_pkg::rmq_entry_type)),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.inc_count) begin
         count_ff <= count_ff + CntW'(1);
      end else if (cmd.dec_count) begin
         count_ff <= count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff         <= req_bus.mode;
         entry_ff.handle <= req_bus.entry_handle;
         entry_ff.source <= req_bus.entry_source;
         entry_ff.tag    <= req_bus.entry_tag;
         entry_ff.comm   <= req_bus.entry_comm;
         q_source_ff     <= req_bus.query_source;
         q_tag_ff        <= req_bus.query_tag;
         q_comm_ff       <= req_bus.query_comm;
         any_source_ff   <= req_bus.any_source;
         any_tag_ff      <= req_bus.any_tag;
         idx_ff          <= '0;
         found_ff        <= 1'b0;
         handle_ff       <= '0;
      end else if (cmd.eval) begin
         if (!found_ff && stat.hit) begin
            found_ff  <= 1'b1;
            handle_ff <= rd_entry.handle;
         end
         idx_ff <= idx_ff + IdxW'(1);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.load_out) begin
         out_status_ff <= status_ff;
         out_handle_ff <= handle_ff;
         out_occ_ff    <= rmq_pkg::OccWidth'(count_ff);
      end
   end

   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.found_handle = out_handle_ff;
   assign rsp_bus.occupancy    = out_occ_ff;

endmodule

// ----- src/rmq_controller.sv -----
// ----------------------------------------------------------------------------
// rmq_controller: sequencing of one queue operation
// Walks enqueue, scan and result hand-off, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module rmq_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [rmq_pkg::ModeWidth-1:0] req_mode,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  rmq_pkg::rmq_stat_type         stat,
   output rmq_pkg::rmq_cmd_type          cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ,
      S_READ,
      S_EVAL,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               unique case (req_mode) inside
                  rmq_pkg::MODE_ENQ: state_in = S_ENQ;
                  rmq_pkg::MODE_DEQ, rmq_pkg::MODE_MATCH: begin
                     if (stat.empty) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = rmq_pkg::ST_NONE;
                        state_in        = S_FINISH;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = rmq_pkg::ST_NONE;
                     state_in        = S_FINISH;
                  end
               endcase
            end
         end
         S_ENQ: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = stat.full ? rmq_pkg::ST_FULL : rmq_pkg::ST_DONE;
            cmd.enq_write   = !stat.full;
            cmd.inc_count   = !stat.full;
            state_in        = S_FINISH;
         end
         S_READ: begin
            // RAM read of the current slot is in flight
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = (stat.found || stat.hit) ? rmq_pkg::ST_DONE
                                                          : rmq_pkg::ST_NONE;
               cmd.dec_count   = stat.found || stat.hit;
               state_in        = S_FINISH;
            end else begin
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/rmq_checker.sv -----
// ----------------------------------------------------------------------------
// rmq_checker: port-level checks for the request match queue
// Watches both channels and flags result or flow-control slips.
// ----------------------------------------------------------------------------
module rmq_checker #(
   parameter int DEPTH = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rmq_pkg::StatusWidth-1:0] status,
   input logic [rmq_pkg::HandleWidth-1:0] found_handle,
   input logic [rmq_pkg::OccWidth-1:0]    occupancy
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
                                  $stable(found_handle) && $stable(occupancy))
      else $error("rsp changed while stalled");

   // nothing is removed unless the status says so
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != rmq_pkg::ST_DONE) |-> found_handle == '0)
      else $error("handle reported without removal");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(occupancy) <= DEPTH)
      else $error("occupancy above depth");

   // one operation in flight: a request transfer closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind request_match_queue_core rmq_checker #(.DEPTH(DEPTH)) u_rmq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .status       (rsp_bus.status),
   .found_handle (rsp_bus.found_handle),
   .occupancy    (rsp_bus.occupancy)
);

// ----- verif/request_match_queue_checker.sv -----
// ----------------------------------------------------------------------------
// request_match_queue_checker: result checker for the request match queue
// Watches both channels, keeps its own copy of the pending request list,
// works out the status, removed handle and occupancy of every accepted
// request and compares them in order with the results the block returns.
// ----------------------------------------------------------------------------
module request_match_queue_checker #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   rmq_req_if   req_bus,
   rmq_rsp_if   rsp_bus,
   output int   fault_count,
   output int   outstanding
);

   typedef struct packed {
      logic [rmq_pkg::StatusWidth-1:0] status;
      logic [rmq_pkg::HandleWidth-1:0] handle;
      logic [rmq_pkg::OccWidth-1:0]    occupancy;
   } queue_outcome_type;

   rmq_pkg::rmq_entry_type held_entries[$];       // index 0 is the oldest request
   queue_outcome_type      expected_outcomes[$];
   queue_outcome_type      seen;
   queue_outcome_type      want;
   int                     faults = 0;

   // Applies the request on the channel to the pending list and returns its result.
   function automatic queue_outcome_type predict_outcome();
      queue_outcome_type      res;
      rmq_pkg::rmq_entry_type slot;
      int                     hit;
      res.status = rmq_pkg::ST_NONE;
      res.handle = '0;
      hit        = -1;
      case (req_bus.mode)
         rmq_pkg::MODE_ENQ: begin
            if (held_entries.size() >= DEPTH) begin
               res.status = rmq_pkg::ST_FULL;
            end else begin
               slot.handle = req_bus.entry_handle;
               slot.source = req_bus.entry_source;
               slot.tag    = req_bus.entry_tag;
               slot.comm   = req_bus.entry_comm;
               held_entries.push_back(slot);
               res.status = rmq_pkg::ST_DONE;
            end
         end
         rmq_pkg::MODE_DEQ: begin
            if (held_entries.size() > 0) begin
               slot       = held_entries.pop_front();
               res.handle = slot.handle;
               res.status = rmq_pkg::ST_DONE;
            end
         end
         rmq_pkg::MODE_MATCH: begin
            foreach (held_entries[i]) begin
               if (hit < 0 &&
                   (req_bus.any_source || held_entries[i].source == req_bus.query_source) &&
                   (req_bus.any_tag || held_entries[i].tag == req_bus.query_tag) &&
                   held_entries[i].comm == req_bus.query_comm) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               res.handle = held_entries[hit].handle;
               held_entries.delete(hit);
               res.status = rmq_pkg::ST_DONE;
            end
         end
         default: ;  // unused mode leaves the list alone
      endcase
      res.occupancy = rmq_pkg::OccWidth'(held_entries.size());
      return res;
   endfunction

   task automatic report_fault(input string what, input queue_outcome_type exp_r,
                               input queue_outcome_type got_r);
      if (faults < 10) begin
         $display("%s: status exp %0d got %0d, handle exp %h got %h, occupancy exp %0d got %0d",
                  what, exp_r.status, got_r.status, exp_r.handle, got_r.handle,
                  exp_r.occupancy, got_r.occupancy);
      end
      faults++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_entries.delete();
         expected_outcomes.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status    = rsp_bus.status;
            seen.handle    = rsp_bus.found_handle;
            seen.occupancy = rsp_bus.occupancy;
            if (expected_outcomes.size() == 0) begin
               report_fault("unexpected result", '0, seen);
            end else begin
               want = expected_outcomes.pop_front();
               if (want.status !== seen.status || want.handle !== seen.handle ||
                   want.occupancy !== seen.occupancy) begin
                  report_fault("result mismatch", want, seen);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_outcomes.push_back(predict_outcome());
         end
      end
      fault_count <= faults;
      outstanding <= expected_outcomes.size();
   end

endmodule

// ----- verif/request_match_queue_test.sv -----
// ----------------------------------------------------------------------------
// request_match_queue_test: testbench top for the request match queue
// Drives directed corner requests (empty, full, exact and wildcard matches,
// unused mode) and then phases of random enqueue, dequeue and match traffic
// over a small key space, with random gaps and result stalls. The checker
// beside the block does the prediction; this top gives the verdict.
// ----------------------------------------------------------------------------
module request_match_queue_test;

   localparam int QUEUE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 830;
   localparam int PHASE_ITEMS   = 50;
   localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 10;
   localparam int IDLE_LIMIT    = 400;

   localparam logic [rmq_pkg::ModeWidth-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [rmq_pkg::ModeWidth-1:0]   mode;
      logic [rmq_pkg::HandleWidth-1:0] entry_handle;
      logic [rmq_pkg::SourceWidth-1:0] entry_source;
      logic [rmq_pkg::TagWidth-1:0]    entry_tag;
      logic [rmq_pkg::CommWidth-1:0]   entry_comm;
      logic [rmq_pkg::SourceWidth-1:0] query_source;
      logic [rmq_pkg::TagWidth-1:0]    query_tag;
      logic [rmq_pkg::CommWidth-1:0]   query_comm;
      logic                            any_source;
      logic                            any_tag;
   } queue_request_type;

   logic clock;
   logic reset;
   logic steady;        // no gaps or stalls in this phase
   int   fault_count;
   int   outstanding;
   int   idle_cycles = 0;
   int   rsp_hold;
   int   rsp_wait;

   rmq_req_if req_bus();
   rmq_rsp_if rsp_bus();

   request_match_queue_core #(.DEPTH(QUEUE_DEPTH)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   request_match_queue_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .fault_count (fault_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: after each transfer drop ready for a random stall, none in a steady phase
   initial begin
      rsp_bus.ready <= 1'b1;
      rsp_hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_wait = steady ? 0 : $urandom_range(4, 0);
            rsp_bus.ready <= (rsp_wait == 0);
            rsp_hold = rsp_wait;
         end else if (rsp_hold != 0) begin
            rsp_hold = rsp_hold - 1;
            if (rsp_hold == 0) rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic queue_request_type make_request(
      input logic [rmq_pkg::ModeWidth-1:0] mode, input logic [15:0] e_handle,
      input logic [15:0] e_source, input logic [15:0] e_tag, input logic [7:0] e_comm,
      input logic [15:0] q_source, input logic [15:0] q_tag, input logic [7:0] q_comm,
      input logic any_src, input logic any_tg);
      queue_request_type r;
      r.mode         = mode;
      r.entry_handle = e_handle;
      r.entry_source = e_source;
      r.entry_tag    = e_tag;
      r.entry_comm   = e_comm;
      r.query_source = q_source;
      r.query_tag    = q_tag;
      r.query_comm   = q_comm;
      r.any_source   = any_src;
      r.any_tag      = any_tg;
      return r;
   endfunction

   // mostly tiny keys so matches hit; now and then a full-range value
   function automatic logic [15:0] draw_key();
      if ($urandom_range(3, 0) == 0) return 16'($urandom);
      return 16'($urandom_range(3, 0));
   endfunction

   // phase flavor: 0 fill, 1 drain, 2 balanced, 3 match heavy
   function automatic queue_request_type random_request(input int flavor);
      queue_request_type r;
      int                pick;
      int                enq_share;
      enq_share = (flavor == 0) ? 70 : (flavor == 1) ? 25 : (flavor == 2) ? 45 : 35;
      pick      = $urandom_range(99, 0);
      if (pick < 4) r.mode = MODE_UNUSED;
      else if (pick < 4 + enq_share) r.mode = rmq_pkg::MODE_ENQ;
      else if (pick < 4 + enq_share + (96 - enq_share) / 3) r.mode = rmq_pkg::MODE_DEQ;
      else r.mode = rmq_pkg::MODE_MATCH;
      r.entry_handle = 16'($urandom);
      r.entry_source = draw_key();
      r.entry_tag    = draw_key();
      r.entry_comm   = 8'(draw_key());
      r.query_source = draw_key();
      r.query_tag    = draw_key();
      r.query_comm   = 8'(draw_key());
      r.any_source   = ($urandom_range(9, 0) < 3);
      r.any_tag      = ($urandom_range(9, 0) < 3);
      return r;
   endfunction

   // entered and left at a rising edge; returns at the edge of the transfer
   task automatic send_request(input queue_request_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(4, 0);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= r.mode;
      req_bus.entry_handle <= r.entry_handle;
      req_bus.entry_source <= r.entry_source;
      req_bus.entry_tag    <= r.entry_tag;
      req_bus.entry_comm   <= r.entry_comm;
      req_bus.query_source <= r.query_source;
      req_bus.query_tag    <= r.query_tag;
      req_bus.query_comm   <= r.query_comm;
      req_bus.any_source   <= r.any_source;
      req_bus.any_tag      <= r.any_tag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   initial begin
      int flavor;
      flavor = 2;
      reset  <= 1'b1;
      steady <= 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= rmq_pkg::MODE_ENQ;
      req_bus.entry_handle <= '0;
      req_bus.entry_source <= '0;
      req_bus.entry_tag    <= '0;
      req_bus.entry_comm   <= '0;
      req_bus.query_source <= '0;
      req_bus.query_tag    <= '0;
      req_bus.query_comm   <= '0;
      req_bus.any_source   <= 1'b0;
      req_bus.any_tag      <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // removal and unused mode on an empty queue
      send_request(make_request(rmq_pkg::MODE_DEQ, 16'h1234, 1, 2, 3, 4, 5, 6,
                                1'b1, 1'b0));
      send_request(make_request(rmq_pkg::MODE_MATCH, 16'h0, 0, 0, 0, 0, 0, 0,
                                1'b1, 1'b1));
      send_request(make_request(MODE_UNUSED, 16'hBEEF, 7, 7, 7, 7, 7, 7, 1'b1, 1'b1));

      // fill to the top with extreme entries first, then a refused enqueue
      send_request(make_request(rmq_pkg::MODE_ENQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                16'h0, 16'h0, 8'h0, 1'b1, 1'b1));
      send_request(make_request(rmq_pkg::MODE_ENQ, 16'h0, 16'h0, 16'h0, 8'h0,
                                16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
      for (int i = 2; i < QUEUE_DEPTH; i++) begin
         send_request(make_request(rmq_pkg::MODE_ENQ, 16'(i + 16'h100),
                                   16'(i % 4), 16'(i % 3),
                                   8'(i % 2), draw_key(), draw_key(), 8'(draw_key()),
                                   1'($urandom), 1'($urandom)));
      end
      send_request(make_request(rmq_pkg::MODE_ENQ, 16'hAAAA, 1, 1, 1, 1, 1, 1,
                                1'b0, 1'b0));

      // exact hit on the head, wildcard hits in the middle, a miss, a dequeue
      send_request(make_request(rmq_pkg::MODE_MATCH, 16'h5555, 0, 0, 0,
                                16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
      send_request(make_request(rmq_pkg::MODE_MATCH, 16'h0, 0, 0, 0,
                                2, 16'hFFFF, 0, 1'b0, 1'b1));
      send_request(make_request(rmq_pkg::MODE_MATCH, 16'h0, 0, 0, 0,
                                16'hFFFF, 1, 1, 1'b1, 1'b0));
      send_request(make_request(rmq_pkg::MODE_MATCH, 16'h0, 0, 0, 0,
                                0, 0, 8'hAA, 1'b1, 1'b1));
      send_request(make_request(rmq_pkg::MODE_DEQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            flavor = $urandom_range(3, 0);
            steady <= ($urandom_range(4, 0) == 0);
         end
         send_request(random_request(flavor));
      end
      req_bus.valid <= 1'b0;

      // the checker's outstanding count is registered and trails the last transfer
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/rmq_pkg.sv
src/rmq_req_if.sv
src/rmq_rsp_if.sv
src/rmq_ram.sv
src/rmq_datapath.sv
src/rmq_controller.sv
src/request_match_queue_core.sv
src/rmq_checker.sv
verif/request_match_queue_checker.sv
verif/request_match_queue_test.sv
